// ----- design/frame_mosaic_address_gen_defines.svh -----
// Assertion macros used by the mosaic address generator top level.
`ifndef FRAME_MOSAIC_ADDRESS_GEN_DEFINES_SVH
`define FRAME_MOSAIC_ADDRESS_GEN_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define FMAG_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("mosaic address generator check failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define FMAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("mosaic address generator check failed");

`else

`define FMAG_ASSERT(label, prop)
`define FMAG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/fmag_pkg.sv -----
// Shared constants, codes and controller interface types of the mosaic address generator.
`default_nettype none

package fmag_pkg;

    // Layout limits.
    localparam int unsigned MAX_TILE_DIM   = 4096;
    localparam int unsigned MAX_FRAMES     = 1024;
    localparam int unsigned MAX_MOSAIC_DIM = 65535;

    // Saturation value of the pixel column counter.
    localparam logic [12:0] COL_CAP = 13'h1FFF;

    // Column-count divider: one quotient bit per cycle.
    localparam int unsigned DIV_STEPS = 11;
    localparam int unsigned DIV_CNT_W = 4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_PER_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_MARGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT     = 3'd5;

    // Input opcodes and result kinds.
    localparam logic OP_BEGIN    = 1'b0;
    localparam logic OP_PIXEL    = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Operand selection of the shared multiplier pair.
    typedef enum logic [1:0] {
        MUL_SEARCH,
        MUL_WIDTH,
        MUL_HEIGHT
    } t_mul_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch;
        logic     pix_start;
        logic     pix_eval;
        logic     pix_mul;
        logic     emit_pixel;
        logic     begin_init;
        logic     div_start;
        logic     mul_load;
        t_mul_sel mul_sel;
        logic     nl_inc;
        logic     sum_w;
        logic     sum_h;
        logic     emit_report;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_opcode;
        logic out_free;
        logic keep;
        logic init_err;
        logic div_done;
        logic auto_cols;
        logic search_more;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/fmag_div.sv -----
// Iterative restoring divider that yields one quotient bit per cycle.
`default_nettype none

module fmag_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [10:0] i_num,
    input  logic [10:0] i_den,
    output logic        o_done,
    output logic [10:0] o_quot
);
    import fmag_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [10:0]          r_rem;
    logic [10:0]          r_quo;
    logic [10:0]          r_den;

    logic [11:0] trial;
    logic [11:0] trial_sub;
    logic        fits;

    // Shift the next numerator bit into the partial remainder and try the subtraction.
    always_comb begin
        trial     = {r_rem, r_quo[10]};
        trial_sub = trial - {1'b0, r_den};
        fits      = (trial >= {1'b0, r_den});
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[10:0] : trial[10:0];
            r_quo <= {r_quo[9:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ----- design/fmag_datapath.sv -----
// Datapath of the mosaic address generator: registers, layout arithmetic and address maths.
`default_nettype none

module fmag_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fmag_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [12:0]                         i_cfg_data,
    input  logic                                i_opcode,
    input  logic [12:0]                         i_frame_cols,
    input  logic [12:0]                         i_frame_rows,
    input  logic [10:0]                         i_frame_count,
    input  logic                                i_frame_start,
    input  logic [7:0]                          i_pixel_value,
    input  logic                                i_out_stall,
    input  fmag_pkg::t_cmd                      i_cmd,
    output fmag_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic                                o_result_kind,
    output logic [15:0]                         o_mosaic_width,
    output logic [15:0]                         o_mosaic_height,
    output logic [10:0]                         o_tiles_per_row,
    output logic [7:0]                          o_fill_level,
    output logic [31:0]                         o_write_address,
    output logic [7:0]                          o_write_value,
    output logic                                o_layout_error
);
    import fmag_pkg::*;

    // Configuration registers.
    logic [7:0]  r_cpr;
    logic [7:0]  r_inner;
    logic [7:0]  r_outer;
    logic [7:0]  r_level;
    logic [12:0] r_tw_cfg;
    logic [12:0] r_th_cfg;

    // Latched input beat.
    logic        r_fs;
    logic [12:0] r_fc;
    logic [12:0] r_fr;
    logic [10:0] r_fk;
    logic [7:0]  r_pv;

    // Layout and tile walk state.
    logic [12:0] r_tile_w;
    logic [12:0] r_tile_h;
    logic [10:0] r_rows_used;
    logic [15:0] r_mosaic_w;
    logic [10:0] r_tile_idx;
    logic [15:0] r_org_x;
    logic [15:0] r_org_y;
    logic [12:0] r_pix_col;
    logic [12:0] r_pix_row;
    logic        r_first_pend;
    logic [7:0]  r_lat_inner;
    logic [10:0] r_frames_total;
    logic [10:0] r_frames_begun;
    logic        r_frame_live;

    // Layout computation scratch.
    logic [12:0] r_nx;
    logic [12:0] r_ny;
    logic [10:0] r_k;
    logic        r_err;
    logic [10:0] r_nl;
    logic [10:0] r_nr;
    logic        r_auto;
    logic [23:0] r_pa;
    logic [23:0] r_pb;
    logic [24:0] r_ow;
    logic [24:0] r_oh;

    // Pixel address scratch.
    logic        r_keep;
    logic [16:0] r_sum_x;
    logic [16:0] r_sum_y;
    logic [31:0] r_prod;

    // Output register.
    logic        r_out_valid;
    logic        r_kind;
    logic [15:0] r_mw;
    logic [15:0] r_mh;
    logic [10:0] r_tpr;
    logic [7:0]  r_fill;
    logic [31:0] r_addr;
    logic [7:0]  r_wval;
    logic        r_lerr;

    logic        div_done;
    logic [10:0] div_quot;
    logic [11:0] div_num;

    // Begin: tile size from configuration or the first frame, and range checks.
    logic [12:0] nx_c;
    logic [12:0] ny_c;
    logic        init_err;

    always_comb begin
        nx_c     = (r_tw_cfg != 13'd0) ? r_tw_cfg : r_fc;
        ny_c     = (r_th_cfg != 13'd0) ? r_th_cfg : r_fr;
        init_err = (r_fk == 11'd0) || (32'(r_fk) > MAX_FRAMES)
                || (32'(nx_c) > MAX_TILE_DIM) || (32'(ny_c) > MAX_TILE_DIM);
    end

    // Shared multiplier pair, operands chosen by the controller.
    logic [12:0] mul_a1, mul_a2;
    logic [10:0] mul_b1, mul_b2;
    logic [23:0] prod1, prod2;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SEARCH: begin
                mul_a1 = r_nx;
                mul_b1 = r_nl;
                mul_a2 = r_ny;
                mul_b2 = r_nr;
            end
            MUL_WIDTH: begin
                mul_a1 = {5'd0, r_inner};
                mul_b1 = r_nl - 11'd1;
                mul_a2 = r_nx;
                mul_b2 = r_nl;
            end
            MUL_HEIGHT: begin
                mul_a1 = {5'd0, r_inner};
                mul_b1 = r_nr - 11'd1;
                mul_a2 = r_ny;
                mul_b2 = r_nr;
            end
            default: begin
                mul_a1 = r_nx;
                mul_b1 = r_nl;
                mul_a2 = r_ny;
                mul_b2 = r_nr;
            end
        endcase
        prod1 = 24'(mul_a1) * 24'(mul_b1);
        prod2 = 24'(mul_a2) * 24'(mul_b2);
    end

    // Automatic layout: keep widening while the grid is narrower than four to three.
    logic [25:0] width_x3;
    logic [25:0] height_x4;
    logic        search_more;

    always_comb begin
        width_x3    = {2'b00, r_pa} + {1'b0, r_pa, 1'b0};
        height_x4   = {r_pb, 2'b00};
        search_more = (r_nl < r_k) && (width_x3 < height_x4);
    end

    // Final size check of the report.
    logic report_err;

    assign report_err = r_err || (32'(r_ow) > MAX_MOSAIC_DIM) || (32'(r_oh) > MAX_MOSAIC_DIM);

    // Pixel placement: centring offset truncated toward zero, then crop to the tile.
    logic signed [14:0] dx, dy, off_x, off_y, tx, ty;
    logic               in_frame, keep_x, keep_y;
    logic [13:0]        row_inc;
    logic               row_wrap;
    logic [11:0]        idx_inc;

    always_comb begin
        dx       = $signed({2'b00, r_tile_w}) - $signed({2'b00, r_fc});
        dy       = $signed({2'b00, r_tile_h}) - $signed({2'b00, r_fr});
        off_x    = (dx + $signed({14'd0, dx[14]})) >>> 1;
        off_y    = (dy + $signed({14'd0, dy[14]})) >>> 1;
        tx       = $signed({2'b00, r_pix_col}) + off_x;
        ty       = $signed({2'b00, r_pix_row}) + off_y;
        in_frame = (r_pix_col < r_fc) && (r_pix_row < r_fr);
        keep_x   = !tx[14] && (tx[13:0] < {1'b0, r_tile_w});
        keep_y   = !ty[14] && (ty[13:0] < {1'b0, r_tile_h});
        row_inc  = {1'b0, r_pix_row} + 14'd1;
        row_wrap = (row_inc >= {1'b0, r_fr});
        idx_inc  = {1'b0, r_tile_idx} + 12'd1;
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr    <= 8'd0;
            r_inner  <= 8'd1;
            r_outer  <= 8'd1;
            r_level  <= 8'd0;
            r_tw_cfg <= 13'd0;
            r_th_cfg <= 13'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS_PER_ROW: r_cpr    <= i_cfg_data[7:0];
                CFG_INNER_MARGIN:    r_inner  <= i_cfg_data[7:0];
                CFG_OUTER_MARGIN:    r_outer  <= i_cfg_data[7:0];
                CFG_MARGIN_LEVEL:    r_level  <= i_cfg_data[7:0];
                CFG_TILE_WIDTH:      r_tw_cfg <= i_cfg_data;
                CFG_TILE_HEIGHT:     r_th_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture of an accepted input beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_fs <= i_frame_start;
            r_fc <= i_frame_cols;
            r_fr <= i_frame_rows;
            r_fk <= i_frame_count;
            r_pv <= i_pixel_value;
        end
    end

    // Layout state: cleared by a begin, committed by a good report, walked by pixels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w       <= '0;
            r_tile_h       <= '0;
            r_rows_used    <= '0;
            r_mosaic_w     <= '0;
            r_tile_idx     <= '0;
            r_org_x        <= '0;
            r_org_y        <= '0;
            r_pix_col      <= '0;
            r_pix_row      <= '0;
            r_first_pend   <= 1'b1;
            r_lat_inner    <= '0;
            r_frames_total <= '0;
            r_frames_begun <= '0;
            r_frame_live   <= 1'b0;
        end else if (i_cmd.begin_init) begin
            r_tile_w       <= '0;
            r_tile_h       <= '0;
            r_rows_used    <= '0;
            r_mosaic_w     <= '0;
            r_tile_idx     <= '0;
            r_org_x        <= {8'd0, r_outer};
            r_org_y        <= {8'd0, r_outer};
            r_pix_col      <= '0;
            r_pix_row      <= '0;
            r_first_pend   <= 1'b1;
            r_lat_inner    <= r_inner;
            r_frames_total <= '0;
            r_frames_begun <= '0;
            r_frame_live   <= 1'b0;
        end else if (i_cmd.emit_report) begin
            if (!report_err) begin
                r_tile_w       <= r_nx;
                r_tile_h       <= r_ny;
                r_rows_used    <= r_nl;
                r_mosaic_w     <= r_ow[15:0];
                r_frames_total <= r_k;
            end
        end else if (i_cmd.pix_start) begin
            if (r_fs) begin
                r_pix_col <= '0;
                r_pix_row <= '0;
                if (r_first_pend) begin
                    r_first_pend <= 1'b0;
                    r_frame_live <= (r_frames_total != 11'd0);
                    if (r_frames_total != 11'd0) begin
                        r_frames_begun <= 11'd1;
                    end
                end else if (r_frame_live && (r_frames_begun < r_frames_total)) begin
                    // Next tile: along the row, or to the start of the next row.
                    r_frames_begun <= r_frames_begun + 11'd1;
                    if (idx_inc >= {1'b0, r_rows_used}) begin
                        r_tile_idx <= '0;
                        r_org_x    <= {8'd0, r_outer};
                        r_org_y    <= 16'(r_org_y + {8'd0, r_lat_inner} + {3'd0, r_tile_h});
                    end else begin
                        r_tile_idx <= idx_inc[10:0];
                        r_org_x    <= 16'(r_org_x + {8'd0, r_lat_inner} + {3'd0, r_tile_w});
                    end
                end else begin
                    r_frame_live <= 1'b0;
                end
            end
        end else if (i_cmd.pix_eval) begin
            // Column-major walk; the column counter saturates past the frame end.
            if (r_frame_live) begin
                if (row_wrap) begin
                    r_pix_row <= '0;
                    if (r_pix_col < COL_CAP) begin
                        r_pix_col <= r_pix_col + 13'd1;
                    end
                end else begin
                    r_pix_row <= row_inc[12:0];
                end
            end
        end
    end

    // Layout computation: column search, row count and mosaic size.
    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_init) begin
            r_nx   <= nx_c;
            r_ny   <= ny_c;
            r_k    <= r_fk;
            r_err  <= init_err;
            r_nl   <= (r_cpr != 8'd0) ? {3'd0, r_cpr} : 11'd1;
            r_auto <= (r_cpr == 8'd0);
        end
        if (i_cmd.nl_inc) begin
            r_nl <= r_nl + 11'd1;
        end
        if (div_done) begin
            r_nr <= div_quot;
        end
        if (i_cmd.mul_load) begin
            r_pa <= prod1;
            r_pb <= prod2;
        end
        if (i_cmd.sum_w) begin
            r_ow <= {16'd0, r_outer, 1'b0} + {1'b0, r_pa} + {1'b0, r_pb};
        end
        if (i_cmd.sum_h) begin
            r_oh <= {16'd0, r_outer, 1'b0} + {1'b0, r_pa} + {1'b0, r_pb};
        end
    end

    // Pixel address: tile coordinates, then row times mosaic width, then the column.
    logic [32:0] row_prod;

    assign row_prod = 33'(r_mosaic_w) * 33'(r_sum_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_eval) begin
            r_keep  <= r_frame_live && in_frame && keep_x && keep_y;
            r_sum_x <= {1'b0, r_org_x} + {4'd0, tx[12:0]};
            r_sum_y <= {1'b0, r_org_y} + {4'd0, ty[12:0]};
        end
        if (i_cmd.pix_mul) begin
            r_prod <= row_prod[31:0];
        end
    end

    // Column-count divider: ceiling of frames over columns.
    assign div_num = {1'b0, r_k} + {1'b0, r_nl} - 12'd1;

    fmag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num[10:0]),
        .i_den   (r_nl),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Output register: a result beat waits here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pixel || i_cmd.emit_report) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pixel) begin
            r_kind <= KIND_PIXEL;
            r_mw   <= '0;
            r_mh   <= '0;
            r_tpr  <= '0;
            r_fill <= '0;
            r_addr <= r_prod + {15'd0, r_sum_x};
            r_wval <= r_pv;
            r_lerr <= 1'b0;
        end else if (i_cmd.emit_report) begin
            r_kind <= KIND_REPORT;
            r_mw   <= report_err ? 16'd0 : r_ow[15:0];
            r_mh   <= report_err ? 16'd0 : r_oh[15:0];
            r_tpr  <= report_err ? 11'd0 : r_nl;
            r_fill <= r_level;
            r_addr <= '0;
            r_wval <= '0;
            r_lerr <= report_err;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.in_opcode   = i_opcode;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
        o_stat.keep        = r_keep;
        o_stat.init_err    = init_err;
        o_stat.div_done    = div_done;
        o_stat.auto_cols   = r_auto;
        o_stat.search_more = search_more;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_mosaic_width  = r_mw;
    assign o_mosaic_height = r_mh;
    assign o_tiles_per_row = r_tpr;
    assign o_fill_level    = r_fill;
    assign o_write_address = r_addr;
    assign o_write_value   = r_wval;
    assign o_layout_error  = r_lerr;

endmodule

`default_nettype wire

// ----- design/fmag_ctrl.sv -----
// Controller state machine of the mosaic address generator.
`default_nettype none

module fmag_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fmag_pkg::t_stat i_stat,
    output fmag_pkg::t_cmd  o_cmd
);
    import fmag_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PSTART,
        S_PKEEP,
        S_PMUL,
        S_PEMIT,
        S_BINIT,
        S_BDIV,
        S_BWAIT,
        S_BMUL,
        S_BCMP,
        S_SZW,
        S_SZH,
        S_SZE,
        S_BREP
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;
    logic   n_stall;

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_SEARCH;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_stall) begin
                    o_cmd.latch = 1'b1;
                    n_state     = (i_stat.in_opcode == OP_PIXEL) ? S_PSTART : S_BINIT;
                end
            end
            S_PSTART: begin
                o_cmd.pix_start = 1'b1;
                n_state         = S_PKEEP;
            end
            S_PKEEP: begin
                o_cmd.pix_eval = 1'b1;
                n_state        = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.pix_mul = 1'b1;
                n_state       = S_PEMIT;
            end
            S_PEMIT: begin
                if (!i_stat.keep) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_pixel = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_BINIT: begin
                o_cmd.begin_init = 1'b1;
                n_state          = i_stat.init_err ? S_BREP : S_BDIV;
            end
            S_BDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_BWAIT;
            end
            S_BWAIT: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.auto_cols ? S_BMUL : S_SZW;
                end
            end
            S_BMUL: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = MUL_SEARCH;
                n_state        = S_BCMP;
            end
            S_BCMP: begin
                if (i_stat.search_more) begin
                    o_cmd.nl_inc = 1'b1;
                    n_state      = S_BDIV;
                end else begin
                    n_state = S_SZW;
                end
            end
            S_SZW: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = MUL_WIDTH;
                n_state        = S_SZH;
            end
            S_SZH: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_sel  = MUL_HEIGHT;
                o_cmd.sum_w    = 1'b1;
                n_state        = S_SZE;
            end
            S_SZE: begin
                o_cmd.sum_h = 1'b1;
                n_state     = S_BREP;
            end
            S_BREP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_report = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    // State and the registered input stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;

endmodule

`default_nettype wire

// ----- design/frame_mosaic_address_gen.sv -----
// Pixel beat: PSTART, PKEEP and PMUL, then PEMIT loads a kept pixel once the output is free.
// Begin beat: BINIT, the bit-serial divider, SZW, SZH, SZE and BREP; automatic layout reruns
// the divider, BMUL and BCMP for each candidate count, up to frame_count candidates.
// Inputs are taken one beat at a time; a waiting result does not block the next beat.
// Reset is synchronous and active low; it restores the register reset values at once.
`default_nettype none

`include "frame_mosaic_address_gen_defines.svh"

module frame_mosaic_address_gen (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fmag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [12:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [12:0]                    i_frame_cols,
    input  logic [12:0]                    i_frame_rows,
    input  logic [10:0]                    i_frame_count,
    input  logic                           i_frame_start,
    input  logic [7:0]                     i_pixel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_result_kind,
    output logic [15:0]                    o_mosaic_width,
    output logic [15:0]                    o_mosaic_height,
    output logic [10:0]                    o_tiles_per_row,
    output logic [7:0]                     o_fill_level,
    output logic [31:0]                    o_write_address,
    output logic [7:0]                     o_write_value,
    output logic                           o_layout_error
);
    import fmag_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    fmag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fmag_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_frame_cols    (i_frame_cols),
        .i_frame_rows    (i_frame_rows),
        .i_frame_count   (i_frame_count),
        .i_frame_start   (i_frame_start),
        .i_pixel_value   (i_pixel_value),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_mosaic_width  (o_mosaic_width),
        .o_mosaic_height (o_mosaic_height),
        .o_tiles_per_row (o_tiles_per_row),
        .o_fill_level    (o_fill_level),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_layout_error  (o_layout_error)
    );

    // Checks on the control flow and on result contents.
    logic in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    `FMAG_ASSERT_NEXT(a_busy_after_accept, in_accept, o_in_stall)
    `FMAG_ASSERT(a_valid_from_emit, $rose(o_out_valid) |-> $past(w_cmd.emit_pixel || w_cmd.emit_report))
    `FMAG_ASSERT(a_pixel_no_report, (o_out_valid && (o_result_kind == KIND_PIXEL)) |-> (!o_layout_error && (o_tiles_per_row == 11'd0)))
    `FMAG_ASSERT(a_error_zero_size, (o_out_valid && (o_result_kind == KIND_REPORT) && o_layout_error) |-> ((o_mosaic_width == 16'd0) && (o_tiles_per_row == 11'd0)))

endmodule

`default_nettype wire

// ----- tb/frame_mosaic_address_gen_tb.sv -----
// Self-checking testbench for the mosaic address generator: layouts, frame streams and config.
module frame_mosaic_address_gen_tb;

    import fmag_pkg::*;

    // Guard against a hang; the slowest correct run has about 2000 beats at the longest gaps and
    // stalls, plus a few full automatic column searches.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;

    // Index beyond the register file; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic        op;
        logic [12:0] cols;
        logic [12:0] rows;
        logic [10:0] count;
        logic        start;
        logic [7:0]  value;
    } t_beat;

    typedef struct {
        t_beat       beat;
        int unsigned gap;
    } t_queued_beat;

    typedef struct packed {
        logic        kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [10:0] tiles;
        logic [7:0]  fill;
        logic [31:0] addr;
        logic [7:0]  value;
        logic        err;
    } t_mosaic_out;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [12:0]          cfg_data = '0;

    logic  drv_valid = 1'b0;
    t_beat drv_beat = '0;
    logic  out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    t_mosaic_out dut_out;

    // Stimulus and checking bookkeeping.
    t_queued_beat pending_beats[$];
    t_mosaic_out  due_mosaic_outputs[$];
    int unsigned  drv_wait = 0;
    int unsigned  seq_gap_max = 0;
    int unsigned  rx_wait = 0;
    int unsigned  rx_gap_max = 0;
    int unsigned  rx_hold_left = 0;
    logic         rx_hold_req = 1'b0;
    logic         in_took = 1'b0;
    logic         out_took = 1'b0;
    logic         failed = 1'b0;
    int           mosaic_items = 0;
    int           cycle_count = 0;

    // Register copies, at their reset values.
    int unsigned cfg_cols = 0;
    int unsigned cfg_inner = 1;
    int unsigned cfg_outer = 1;
    int unsigned cfg_level = 0;
    int unsigned cfg_tile_w = 0;
    int unsigned cfg_tile_h = 0;

    // Layout and scan state of the predictor.
    int unsigned lay_tile_w = 0;
    int unsigned lay_tile_h = 0;
    int unsigned lay_cols = 0;
    int unsigned lay_mosaic_w = 0;
    int unsigned tile_in_row = 0;
    int unsigned org_x = 0;
    int unsigned org_y = 0;
    int unsigned pix_col = 0;
    int unsigned pix_row = 0;
    int unsigned lat_inner = 0;
    int unsigned frames_total = 0;
    int unsigned frames_begun = 0;
    bit          first_pending = 1'b1;
    bit          frame_live = 1'b0;

    frame_mosaic_address_gen i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (drv_valid),
        .o_in_stall      (in_stall),
        .i_opcode        (drv_beat.op),
        .i_frame_cols    (drv_beat.cols),
        .i_frame_rows    (drv_beat.rows),
        .i_frame_count   (drv_beat.count),
        .i_frame_start   (drv_beat.start),
        .i_pixel_value   (drv_beat.value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_kind   (dut_out.kind),
        .o_mosaic_width  (dut_out.width),
        .o_mosaic_height (dut_out.height),
        .o_tiles_per_row (dut_out.tiles),
        .o_fill_level    (dut_out.fill),
        .o_write_address (dut_out.addr),
        .o_write_value   (dut_out.value),
        .o_layout_error  (dut_out.err)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result, if any, of one accepted beat and advances the layout state.
    task automatic place_beat(input t_beat b);
        longint unsigned nx, ny, k, nl, nr, ow, oh;
        int          fc, fr, ix, iy, tx, ty;
        int unsigned col_u, row_u;
        bit          err, keep;
        t_mosaic_out r;
        r = '0;
        if (b.op == OP_BEGIN) begin
            nx = (cfg_tile_w != 0) ? cfg_tile_w : b.cols;
            ny = (cfg_tile_h != 0) ? cfg_tile_h : b.rows;
            k = b.count;
            r.kind = KIND_REPORT;
            r.fill = cfg_level[7:0];
            lay_tile_w = 0;
            lay_tile_h = 0;
            lay_cols = 0;
            lay_mosaic_w = 0;
            tile_in_row = 0;
            org_x = cfg_outer;
            org_y = cfg_outer;
            pix_col = 0;
            pix_row = 0;
            first_pending = 1'b1;
            frame_live = 1'b0;
            frames_begun = 0;
            frames_total = 0;
            lat_inner = cfg_inner;
            err = (k == 0 || k > MAX_FRAMES || nx > MAX_TILE_DIM || ny > MAX_TILE_DIM);
            if (!err) begin
                if (cfg_cols != 0) begin
                    nl = cfg_cols;
                end else begin
                    // Smallest column count, up to the frame count, whose grid is at least four to three.
                    nl = 1;
                    while (nl < k && 3 * nl * nx < 4 * ((k + nl - 1) / nl) * ny)
                        nl++;
                end
                nr = (k + nl - 1) / nl;
                ow = 2 * cfg_outer + cfg_inner * (nl - 1) + nx * nl;
                oh = 2 * cfg_outer + cfg_inner * (nr - 1) + ny * nr;
                if (ow > MAX_MOSAIC_DIM || oh > MAX_MOSAIC_DIM) begin
                    err = 1'b1;
                end else begin
                    lay_tile_w = nx;
                    lay_tile_h = ny;
                    lay_cols = nl;
                    lay_mosaic_w = ow;
                    frames_total = k;
                    r.width = ow[15:0];
                    r.height = oh[15:0];
                    r.tiles = nl[10:0];
                end
            end
            r.err = err;
            due_mosaic_outputs.push_back(r);
        end else begin
            fc = b.cols;
            fr = b.rows;
            if (b.start) begin
                pix_col = 0;
                pix_row = 0;
                if (first_pending) begin
                    first_pending = 1'b0;
                    frame_live = (frames_total > 0);
                    if (frame_live)
                        frames_begun = 1;
                end else if (frame_live && frames_begun < frames_total) begin
                    // Next tile: along the row, or down to the start of the next row.
                    frames_begun++;
                    tile_in_row++;
                    if (tile_in_row >= lay_cols) begin
                        tile_in_row = 0;
                        org_x = cfg_outer;
                        org_y += lat_inner + lay_tile_h;
                    end else begin
                        org_x += lat_inner + lay_tile_w;
                    end
                end else begin
                    frame_live = 1'b0;
                end
            end
            if (frame_live) begin
                ix = pix_col;
                iy = pix_row;
                keep = 1'b0;
                if (ix < fc && iy < fr) begin
                    // Centring offsets are signed and truncate toward zero.
                    tx = ix + (int'(lay_tile_w) - fc) / 2;
                    ty = iy + (int'(lay_tile_h) - fr) / 2;
                    keep = (tx >= 0 && tx < int'(lay_tile_w) &&
                            ty >= 0 && ty < int'(lay_tile_h));
                end
                if (keep) begin
                    col_u = tx;
                    row_u = ty;
                    r.kind = KIND_PIXEL;
                    r.addr = lay_mosaic_w * (org_y + row_u) + org_x + col_u;
                    r.value = b.value;
                    due_mosaic_outputs.push_back(r);
                end
                pix_row++;
                if (int'(pix_row) >= fr) begin
                    pix_row = 0;
                    if (pix_col < COL_CAP)
                        pix_col++;
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 18;
        endcase
    endfunction

    function automatic int pick_side();
        case ($urandom_range(0, 15))
            0: return $urandom_range(1, 4096);
            1: return 4096;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_margin();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    endfunction

    function automatic int unsigned pick_tile();
        case ($urandom_range(0, 19))
            0, 1, 2: return $urandom_range(1, 4096);
            3, 4, 5, 6, 7, 8, 9, 10: return 0;
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    task automatic push_beat(input t_beat b);
        t_queued_beat q;
        q.beat = b;
        q.gap = $urandom_range(0, seq_gap_max);
        pending_beats.push_back(q);
    endtask

    task automatic push_begin(input int cols, input int rows, input int count);
        t_beat b;
        b.op = OP_BEGIN;
        b.cols = cols;
        b.rows = rows;
        b.count = count;
        b.start = $urandom_range(0, 1);
        b.value = $urandom_range(0, 255);
        push_beat(b);
        mosaic_items++;
    endtask

    task automatic push_pixel(input int cols, input int rows, input logic start,
                              input int value);
        t_beat b;
        b.op = OP_PIXEL;
        b.cols = cols;
        b.rows = rows;
        b.count = $urandom_range(0, 1024);
        b.start = start;
        b.value = value;
        push_beat(b);
    endtask

    // Column-major pixels of one frame; npix may fall short of or run past the frame.
    task automatic push_frame(input int cols, input int rows, input int npix);
        for (int i = 0; i < npix; i++)
            push_pixel(cols, rows, i == 0, $urandom_range(0, 255));
        mosaic_items += npix;
    endtask

    // A begin beat followed by a handful of frames, mostly well formed.
    task automatic push_mosaic_set();
        int cols, rows, count, frames, c, r, npix;
        seq_gap_max = pick_gap();
        cols = pick_side();
        rows = pick_side();
        case ($urandom_range(0, 19))
            0: count = 0;
            1: count = $urandom_range(13, 1024);
            default: count = $urandom_range(1, 12);
        endcase
        push_begin(cols, rows, count);
        if ($urandom_range(0, 9) == 0)
            push_pixel(cols, rows, 1'b0, $urandom_range(0, 255));
        frames = (count > 5) ? 5 : count;
        if (frames == 0 || $urandom_range(0, 3) == 0)
            frames++;
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 9) < 7) begin
                c = cols;
                r = rows;
            end else begin
                c = pick_side();
                r = pick_side();
            end
            npix = c * r;
            case ($urandom_range(0, 7))
                0: npix = npix + $urandom_range(1, 4);
                1: npix = $urandom_range(1, npix);
                default: ;
            endcase
            if (npix > 48)
                npix = $urandom_range(1, 48);
            push_frame(c, r, npix);
        end
    endtask

    // Stray pixels with random fields, now and then a begin with random fields.
    task automatic push_noise();
        seq_gap_max = pick_gap();
        repeat ($urandom_range(1, 6))
            push_pixel($urandom_range(1, 4096), $urandom_range(1, 4096),
                       $urandom_range(0, 1), $urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            push_begin($urandom_range(1, 4096), $urandom_range(1, 4096),
                       $urandom_range(0, 1024));
    endtask

    // Blocks until every beat is taken and every result has arrived, then lets the block settle.
    task automatic wait_quiet();
        while (pending_beats.size() != 0 || drv_valid || due_mosaic_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[12:0];
        case (idx)
            CFG_COLUMNS_PER_ROW: cfg_cols = value[7:0];
            CFG_INNER_MARGIN:    cfg_inner = value[7:0];
            CFG_OUTER_MARGIN:    cfg_outer = value[7:0];
            CFG_MARGIN_LEVEL:    cfg_level = value[7:0];
            CFG_TILE_WIDTH:      cfg_tile_w = value[12:0];
            CFG_TILE_HEIGHT:     cfg_tile_h = value[12:0];
            default: ;
        endcase
    endtask

    task automatic program_layout(input int unsigned cols, input int unsigned inner,
                                  input int unsigned outer, input int unsigned level,
                                  input int unsigned tile_w, input int unsigned tile_h);
        write_reg(CFG_COLUMNS_PER_ROW, cols);
        write_reg(CFG_INNER_MARGIN, inner);
        write_reg(CFG_OUTER_MARGIN, outer);
        write_reg(CFG_MARGIN_LEVEL, level);
        write_reg(CFG_TILE_WIDTH, tile_w);
        write_reg(CFG_TILE_HEIGHT, tile_h);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int budget);
        int first;
        first = mosaic_items;
        while (mosaic_items - first < budget) begin
            if ($urandom_range(0, 6) == 0)
                push_noise();
            else
                push_mosaic_set();
        end
        wait_quiet();
    endtask

    // Sender: offers queued beats, waiting the drawn gap after each one.
    always @(negedge clk) begin
        t_queued_beat nxt;
        logic         offer;
        offer = drv_valid;
        if (drv_valid && in_took)
            offer = 1'b0;
        if (rst_n && !offer) begin
            if (drv_wait > 0) begin
                drv_wait--;
            end else if (pending_beats.size() != 0) begin
                nxt = pending_beats.pop_front();
                drv_beat <= nxt.beat;
                drv_wait = nxt.gap;
                offer = 1'b1;
            end
        end
        drv_valid <= offer;
    end

    // Receiver: stalls a drawn number of cycles after each beat, or for a long hold when asked.
    always @(negedge clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (out_took) begin
            if ($urandom_range(0, 31) == 0)
                rx_gap_max = pick_gap();
            rx_wait = $urandom_range(0, rx_gap_max);
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: checks each result beat against the oldest expectation, then predicts new ones.
    always @(posedge clk) begin
        t_mosaic_out want;
        cycle_count++;
        in_took <= rst_n && drv_valid && !in_stall;
        out_took <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (due_mosaic_outputs.size() == 0) begin
                $error("result beat with nothing expected: kind %0d address %0d",
                       dut_out.kind, dut_out.addr);
                failed = 1'b1;
            end else begin
                want = due_mosaic_outputs.pop_front();
                check_field("result_kind", want.kind, dut_out.kind);
                check_field("mosaic_width", want.width, dut_out.width);
                check_field("mosaic_height", want.height, dut_out.height);
                check_field("tiles_per_row", want.tiles, dut_out.tiles);
                check_field("fill_level", want.fill, dut_out.fill);
                check_field("write_address", want.addr, dut_out.addr);
                check_field("write_value", want.value, dut_out.value);
                check_field("layout_error", want.err, dut_out.err);
            end
        end
        if (rst_n && drv_valid && !in_stall)
            place_beat(drv_beat);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned cols;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset register values.
        seq_gap_max = 3;
        push_pixel(4096, 4096, 1'b1, 255);      // pixel before any layout
        push_begin(2, 2, 0);                    // no frames: layout error
        push_pixel(2, 2, 1'b1, 0);              // dropped after the error
        push_begin(3, 2, 3);                    // automatic layout, three frames
        push_pixel(3, 2, 1'b0, 17);             // before the first frame start
        push_frame(3, 2, 7);                    // full frame and one pixel past its end
        push_frame(1, 1, 1);                    // small frame centred in its tile
        push_frame(6, 1, 6);                    // wide frame cropped, offset toward zero
        push_frame(2, 2, 1);                    // one frame more than announced
        push_begin(4096, 4096, 1024);           // mosaic beyond the size limit
        wait_quiet();

        // Extreme register settings.
        program_layout(255, 255, 255, 255, 4096, 4096);
        run_phase(40);
        program_layout(0, 0, 0, 0, 0, 0);
        run_phase(150);
        write_reg(CFG_UNUSED_IDX, 13'h1FFF);
        program_layout(0, 1, 1, 9, 1, 4096);
        seq_gap_max = 0;
        push_begin(5, 5, 1024);                 // automatic search runs to every frame
        push_frame(1, 3, 3);
        push_frame(2, 1, 2);
        wait_quiet();
        program_layout(255, 0, 0, 128, 1, 1);
        run_phase(100);
        program_layout(1, 0, 255, 200, 4096, 4096);
        run_phase(100);

        // Random settings; the first phase opens with a long receiver hold.
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 4))
                0, 1: cols = 0;
                2, 3: cols = $urandom_range(1, 6);
                default: cols = $urandom_range(1, 255);
            endcase
            program_layout(cols, pick_margin(), pick_margin(), $urandom_range(0, 255),
                           pick_tile(), pick_tile());
            if (p == 0)
                rx_hold_req = 1'b1;
            run_phase(160);
        end

        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
